FILE: rtl/ffa_pkg.sv
// shared types, constants and the control store of the first-fit allocator
`default_nettype none

package ffa_pkg;

  // field widths fixed by the interface
  localparam int unsigned ARENA_WORDS_DEF = 4096;
  localparam int unsigned OFS_W           = 13;
  localparam int unsigned SIZE_W          = 13;
  localparam int unsigned BYTES_W         = 16;
  localparam int unsigned STATUS_W        = 2;

  // words per header, bytes per word, smallest legal arena
  localparam int unsigned HDR_WORDS  = 2;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int unsigned WORDS_W    = BYTES_W - WORD_SHIFT + 1;
  localparam int unsigned MIN_ARENA  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // control store addresses
  typedef enum logic [3:0] {
    STEP_IDLE      = 4'd0,
    STEP_DISPATCH  = 4'd1,
    STEP_A_LOAD    = 4'd2,
    STEP_A_TEST    = 4'd3,
    STEP_A_CHECK   = 4'd4,
    STEP_A_WR_NEW  = 4'd5,
    STEP_A_LINK    = 4'd6,
    STEP_A_FAIL    = 4'd7,
    STEP_F_LOAD    = 4'd8,
    STEP_F_TEST    = 4'd9,
    STEP_F_CHECK   = 4'd10,
    STEP_F_UNLINK  = 4'd11,
    STEP_F_FAIL    = 4'd12
  } step_e;

  // branch conditions
  typedef enum logic [2:0] {
    COND_ALWAYS       = 3'd0,
    COND_START        = 3'd1,
    COND_FREE         = 3'd2,
    COND_FIT_OR_END   = 3'd3,
    COND_PLACE        = 3'd4,
    COND_MATCH_OR_END = 3'd5,
    COND_CUR_END      = 3'd6
  } cond_e;

  // datapath actions
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_ACCEPT     = 3'd1,
    ACT_LOAD       = 3'd2,
    ACT_ADVANCE    = 3'd3,
    ACT_WR_NEW     = 3'd4,
    ACT_LINK_ALLOC = 3'd5,
    ACT_LINK_FREE  = 3'd6
  } act_e;

  // one control word
  typedef struct packed {
    cond_e   cond;
    step_e   jt;
    step_e   jf;
    act_e    act;
    logic    fin;
    logic    give_ofs;
    status_e status;
  } uword_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic start;
    logic op_free;
    logic fit_or_end;
    logic place;
    logic match_or_end;
    logic cur_end;
  } flags_t;

  // the program: taken branch goes to jt, otherwise jf
  function automatic uword_t ucode_rom(step_e pc);
    uword_t w;
    w = '{cond: COND_ALWAYS, jt: STEP_IDLE, jf: STEP_IDLE, act: ACT_NONE,
          fin: 1'b0, give_ofs: 1'b0, status: ST_OK};
    case (pc)
      STEP_IDLE: begin
        w.cond = COND_START;
        w.jt   = STEP_DISPATCH;
        w.act  = ACT_ACCEPT;
      end
      STEP_DISPATCH: begin
        w.cond = COND_FREE;
        w.jt   = STEP_F_LOAD;
        w.jf   = STEP_A_LOAD;
      end
      // allocate: walk for the first gap that fits
      STEP_A_LOAD: begin
        w.jt  = STEP_A_TEST;
        w.act = ACT_LOAD;
      end
      STEP_A_TEST: begin
        w.cond = COND_FIT_OR_END;
        w.jt   = STEP_A_CHECK;
        w.jf   = STEP_A_LOAD;
        w.act  = ACT_ADVANCE;
      end
      STEP_A_CHECK: begin
        w.cond = COND_PLACE;
        w.jt   = STEP_A_WR_NEW;
        w.jf   = STEP_A_FAIL;
      end
      STEP_A_WR_NEW: begin
        w.jt  = STEP_A_LINK;
        w.act = ACT_WR_NEW;
      end
      STEP_A_LINK: begin
        w.act      = ACT_LINK_ALLOC;
        w.fin      = 1'b1;
        w.give_ofs = 1'b1;
        w.status   = ST_OK;
      end
      STEP_A_FAIL: begin
        w.fin    = 1'b1;
        w.status = ST_NO_SPACE;
      end
      // free: walk for the block whose data offset matches
      STEP_F_LOAD: begin
        w.jt  = STEP_F_TEST;
        w.act = ACT_LOAD;
      end
      STEP_F_TEST: begin
        w.cond = COND_MATCH_OR_END;
        w.jt   = STEP_F_CHECK;
        w.jf   = STEP_F_LOAD;
        w.act  = ACT_ADVANCE;
      end
      STEP_F_CHECK: begin
        w.cond = COND_CUR_END;
        w.jt   = STEP_F_FAIL;
        w.jf   = STEP_F_UNLINK;
      end
      STEP_F_UNLINK: begin
        w.act    = ACT_LINK_FREE;
        w.fin    = 1'b1;
        w.status = ST_OK;
      end
      STEP_F_FAIL: begin
        w.fin    = 1'b1;
        w.status = ST_NOT_FOUND;
      end
      default: begin
        w.jt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/first_fit_block_allocator.sv
// first-fit allocator over a linked list of block headers in a word arena
//
//   channel   ports                                        handshake
//   request   op_i, request_bytes_i, release_offset_i      start & !busy
//   result    status_o, data_offset_o                      done_o, one cycle
//   config    cfg_wdata_i                                  cfg_we_i
//
// a request walks the header list in two steps per header visited (load from
// the header ram, then test), so its run time scales with the blocks passed.
// after the walk, a placed allocate checks, writes the new header and links
// it; a failed allocate and any free finish in the step after the check. a new request
// is taken in the cycle that shows the result. the head header lives in flops,
// so reset and arena writes rebuild it at once; the receiver cannot stall.
`default_nettype none

module first_fit_block_allocator #(
  parameter int unsigned ARENA_WORDS = ffa_pkg::ARENA_WORDS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [ffa_pkg::BYTES_W-1:0]  request_bytes_i,
  input  logic [ffa_pkg::OFS_W-1:0]    release_offset_i,
  input  logic                         cfg_we_i,
  input  logic [ffa_pkg::OFS_W-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic [ffa_pkg::STATUS_W-1:0] status_o,
  output logic [ffa_pkg::OFS_W-1:0]    data_offset_o
);

  localparam int unsigned LinkW  = $clog2(ARENA_WORDS + 1);
  localparam int unsigned AddrW  = $clog2(ARENA_WORDS);
  localparam int unsigned SumW   =
    ((LinkW > ffa_pkg::WORDS_W) ? LinkW : ffa_pkg::WORDS_W) + 2;
  localparam int unsigned EntryW = LinkW + ffa_pkg::SIZE_W;

  ffa_pkg::uword_t uw;
  ffa_pkg::flags_t flags;

  // control state
  logic [LinkW-1:0]                arena_q, arena_d;
  logic [LinkW-1:0]                head_next_q, head_next_d;
  logic                            done_q, done_d;

  // walk and request registers
  logic [LinkW-1:0]                cur_q, cur_d;
  logic [LinkW-1:0]                prev_q, prev_d;
  logic [LinkW-1:0]                nxt_q, nxt_d;
  logic [SumW-1:0]                 used_q, used_d;
  logic [ffa_pkg::SIZE_W-1:0]      size_q, size_d;
  logic [ffa_pkg::SIZE_W-1:0]      psize_q, psize_d;
  logic [ffa_pkg::WORDS_W-1:0]     words_q, words_d;
  logic [ffa_pkg::WORDS_W-1:0]     need_q, need_d;
  logic [ffa_pkg::OFS_W-1:0]       target_q, target_d;
  logic                            op_q, op_d;
  logic [ffa_pkg::STATUS_W-1:0]    status_q, status_d;
  logic [ffa_pkg::OFS_W-1:0]       ofs_q, ofs_d;

  // header ram
  logic                            ram_we;
  logic [AddrW-1:0]                ram_waddr;
  logic [EntryW-1:0]               ram_wdata;
  logic [AddrW-1:0]                ram_raddr;
  logic [EntryW-1:0]               ram_rdata;
  logic [LinkW-1:0]                rd_next;
  logic [ffa_pkg::SIZE_W-1:0]      rd_size;

  // combinational helpers
  logic [LinkW-1:0]                cur_next;
  logic [ffa_pkg::SIZE_W-1:0]      cur_size;
  logic [ffa_pkg::BYTES_W:0]       bytes_round;
  logic [ffa_pkg::WORDS_W-1:0]     req_words;
  logic [SumW-1:0]                 nxt_x;
  logic [SumW-1:0]                 data_sum;
  logic [SumW-1:0]                 cfg_x;
  logic [SumW-1:0]                 cfg_sat;
  logic [LinkW-1:0]                link_val;
  logic                            nxt_end;
  logic                            fit;

  ffa_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw),
    .busy_o  (busy)
  );

  ffa_ram #(
    .WIDTH (EntryW),
    .DEPTH (ARENA_WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_next = ram_rdata[EntryW-1:ffa_pkg::SIZE_W];
  assign rd_size = ram_rdata[ffa_pkg::SIZE_W-1:0];

  // header of the current block: the head sits in flip-flops
  assign cur_next = (cur_q == '0) ? head_next_q : rd_next;
  assign cur_size = (cur_q == '0) ? '0 : rd_size;

  // byte request rounded up to whole words
  assign bytes_round = {1'b0, request_bytes_i} + (ffa_pkg::BYTES_W + 1)'(ffa_pkg::WORD_BYTES - 1);
  assign req_words   = bytes_round[ffa_pkg::BYTES_W:ffa_pkg::WORD_SHIFT];

  // gap and match tests on the registered header
  assign nxt_x   = SumW'(nxt_q);
  assign nxt_end = (nxt_q == arena_q) || (nxt_q >= LinkW'(ARENA_WORDS));
  assign fit     = nxt_x >= (used_q + SumW'(need_q));

  assign flags.start        = start;
  assign flags.op_free      = op_q;
  assign flags.fit_or_end   = fit || nxt_end;
  assign flags.place        = fit && (used_q < SumW'(ARENA_WORDS)) &&
                              ((used_q + SumW'(ffa_pkg::HDR_WORDS)) <= SumW'(arena_q));
  assign flags.match_or_end = nxt_end ||
                              ((nxt_x + SumW'(ffa_pkg::HDR_WORDS)) == SumW'(target_q));
  assign flags.cur_end      = (cur_q == arena_q) || (cur_q >= LinkW'(ARENA_WORDS));

  assign data_sum = used_q + SumW'(ffa_pkg::HDR_WORDS);
  assign link_val = (uw.act == ffa_pkg::ACT_LINK_ALLOC) ? used_q[LinkW-1:0] : rd_next;

  // arena length saturated into the legal range
  assign cfg_x   = SumW'(cfg_wdata_i);
  assign cfg_sat = (cfg_x < SumW'(ffa_pkg::MIN_ARENA)) ? SumW'(ffa_pkg::MIN_ARENA) :
                   (cfg_x > SumW'(ARENA_WORDS))        ? SumW'(ARENA_WORDS) : cfg_x;

  // datapath driven by the control word
  always_comb begin
    arena_d     = arena_q;
    head_next_d = head_next_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    used_d      = used_q;
    size_d      = size_q;
    psize_d     = psize_q;
    words_d     = words_q;
    need_d      = need_q;
    target_d    = target_q;
    op_d        = op_q;
    ram_we      = 1'b0;
    ram_waddr   = used_q[AddrW-1:0];
    ram_wdata   = {nxt_q, words_q[ffa_pkg::SIZE_W-1:0]};

    case (uw.act)
      ffa_pkg::ACT_ACCEPT: begin
        if (start) begin
          op_d     = op_i;
          words_d  = req_words;
          need_d   = req_words + ffa_pkg::WORDS_W'(ffa_pkg::HDR_WORDS);
          target_d = release_offset_i;
          cur_d    = '0;
        end
      end
      ffa_pkg::ACT_LOAD: begin
        nxt_d  = cur_next;
        size_d = cur_size;
        used_d = SumW'(cur_q) + SumW'(cur_size) + SumW'(ffa_pkg::HDR_WORDS);
      end
      ffa_pkg::ACT_ADVANCE: begin
        prev_d  = cur_q;
        psize_d = size_q;
        cur_d   = nxt_q;
      end
      ffa_pkg::ACT_WR_NEW: begin
        ram_we = 1'b1;
      end
      ffa_pkg::ACT_LINK_ALLOC, ffa_pkg::ACT_LINK_FREE: begin
        if (prev_q == '0) begin
          head_next_d = link_val;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = prev_q[AddrW-1:0];
          ram_wdata = {link_val, psize_q};
        end
      end
      default: begin
      end
    endcase

    // arena write rebuilds the head
    if (cfg_we_i) begin
      arena_d     = cfg_sat[LinkW-1:0];
      head_next_d = cfg_sat[LinkW-1:0];
    end
  end

  // read the header that the walk moves to
  assign ram_raddr = cur_d[AddrW-1:0];

  // result transaction
  always_comb begin
    done_d   = uw.fin;
    status_d = status_q;
    ofs_d    = ofs_q;
    if (uw.fin) begin
      status_d = uw.status;
      ofs_d    = uw.give_ofs ? data_sum[ffa_pkg::OFS_W-1:0] : '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q     <= LinkW'(ARENA_WORDS);
      head_next_q <= LinkW'(ARENA_WORDS);
      done_q      <= 1'b0;
    end else begin
      arena_q     <= arena_d;
      head_next_q <= head_next_d;
      done_q      <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    nxt_q    <= nxt_d;
    used_q   <= used_d;
    size_q   <= size_d;
    psize_q  <= psize_d;
    words_q  <= words_d;
    need_q   <= need_d;
    target_q <= target_d;
    op_q     <= op_d;
    status_q <= status_d;
    ofs_q    <= ofs_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign data_offset_o = ofs_q;

endmodule

`default_nettype wire

FILE: rtl/ffa_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/ffa_seq.sv
// microcode sequencer: step counter, control store and branch select
`default_nettype none

module ffa_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffa_pkg::flags_t flags_i,
  output ffa_pkg::uword_t uword_o,
  output logic            busy_o
);

  ffa_pkg::step_e pc_q, pc_d;
  logic           taken;

  assign uword_o = ffa_pkg::ucode_rom(pc_q);

  // branch condition select
  always_comb begin
    case (uword_o.cond)
      ffa_pkg::COND_ALWAYS:       taken = 1'b1;
      ffa_pkg::COND_START:        taken = flags_i.start;
      ffa_pkg::COND_FREE:         taken = flags_i.op_free;
      ffa_pkg::COND_FIT_OR_END:   taken = flags_i.fit_or_end;
      ffa_pkg::COND_PLACE:        taken = flags_i.place;
      ffa_pkg::COND_MATCH_OR_END: taken = flags_i.match_or_end;
      ffa_pkg::COND_CUR_END:      taken = flags_i.cur_end;
      default:                    taken = 1'b1;
    endcase
    pc_d = taken ? uword_o.jt : uword_o.jf;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ffa_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign busy_o = (pc_q != ffa_pkg::STEP_IDLE);

endmodule

`default_nettype wire
